FILE: rtl/core/ifp_pkg.sv
`default_nettype none
package ifp_pkg;

  // Grid geometry: a power-of-two side, so coordinates wrap by truncation
  localparam int GRID_SIDE  = 32;
  localparam int COORD_W    = $clog2(GRID_SIDE);
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W     = 2 * COORD_W;

  // Acceptance threshold table
  localparam int TBL_DEPTH  = 10;
  localparam int TBL_IDX_W  = 4;
  localparam int THR_W      = 33;
  localparam int DRAW_W     = 32;

  // Running spin sum, two's complement, wraps modulo 2^MAG_W
  localparam int MAG_W      = 12;
  localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(CELL_COUNT);

  // Channel widths
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_FLIP  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CAPTURE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // take the input item
    logic rd_en;   // issue the next grid read
    logic exec;    // decide, write back, load the result register
    logic clr_wr;  // write one entry of the clearing pass
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;   // clearing pass writes its last entry
    logic last_read;  // the read being issued is the last one for this item
    logic out_busy;   // result register full and not taken this cycle
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/ifp_ctrl.sv
`default_nettype none
module ifp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire ifp_pkg::sts_t sts,
  output ifp_pkg::ctl_t      ctl
);
  import ifp_pkg::*;

  state_t state_r, state_nxt;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (sts.last_read) state_nxt = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_tready  = 1'b0;
    ctl        = '0;
    case (state_r)
      ST_CLEAR: begin
        ctl.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        ctl.load  = in_tvalid;
      end
      ST_READ: begin
        ctl.rd_en = 1'b1;
      end
      ST_EXEC: begin
        ctl.exec = !sts.out_busy;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/ifp_datapath.sv
`default_nettype none
module ifp_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // x[4:0], y[9:5], random_draw[41:10], entry_index[45:42], load_value[78:46]
  input  wire logic [ifp_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd[1:0]
  input  wire logic [ifp_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // spin[0], flipped[1], magnetization[13:2]
  output logic [ifp_pkg::OUT_DATA_W-1:0]        out_tdata,
  input  wire ifp_pkg::ctl_t                    ctl,
  output ifp_pkg::sts_t                         sts
);
  import ifp_pkg::*;

  localparam int X_LSB     = 0;
  localparam int Y_LSB     = X_LSB + 5;
  localparam int DRAW_LSB  = Y_LSB + 5;
  localparam int ENTRY_LSB = DRAW_LSB + DRAW_W;
  localparam int VALUE_LSB = ENTRY_LSB + TBL_IDX_W;

  // Read order: the site first, then its four wrapped neighbours
  localparam logic [2:0] PH_SITE  = 3'd0;
  localparam logic [2:0] PH_EAST  = 3'd1;
  localparam logic [2:0] PH_WEST  = 3'd2;
  localparam logic [2:0] PH_NORTH = 3'd3;
  localparam logic [2:0] PH_SOUTH = 3'd4;

  cmd_t                   cmd_r;
  logic [COORD_W-1:0]     col_r;
  logic [COORD_W-1:0]     row_r;
  logic [DRAW_W-1:0]      draw_r;
  logic [TBL_IDX_W-1:0]   entry_r;
  logic [THR_W-1:0]       value_r;

  logic [2:0]             phase_r;
  logic                   cap_en_r;
  logic [2:0]             cap_phase_r;
  logic                   mem_q_r;
  logic                   site_r;
  logic [2:0]             ups_r;
  logic [CELL_W-1:0]      clr_addr_r;

  logic                   grid_mem [CELL_COUNT];
  logic [THR_W-1:0]       thr_tbl_r [TBL_DEPTH];

  logic signed [MAG_W-1:0] total_r, total_nxt;

  logic                   out_valid_r;
  logic                   out_spin_r;
  logic                   out_flip_r;
  logic signed [MAG_W-1:0] out_mag_r;

  logic [CELL_W-1:0]      site_addr;
  logic [CELL_W-1:0]      rd_addr;
  logic [TBL_IDX_W-1:0]   tbl_idx;
  logic [THR_W-1:0]       thr;
  logic                   accept_flip;
  logic                   new_bit;
  logic                   do_write;
  logic                   mem_we;

  // Hold the item taken at the input transfer
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= cmd_t'(in_tuser);
      col_r   <= in_tdata[X_LSB +: COORD_W];
      row_r   <= in_tdata[Y_LSB +: COORD_W];
      draw_r  <= in_tdata[DRAW_LSB +: DRAW_W];
      entry_r <= in_tdata[ENTRY_LSB +: TBL_IDX_W];
      value_r <= in_tdata[VALUE_LSB +: THR_W];
    end
  end

  // Advance the read phase; capture follows each read in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SITE;
      cap_en_r <= 1'b0;
    end else begin
      cap_en_r <= ctl.rd_en;
      if (ctl.load) begin
        phase_r <= PH_SITE;
      end else if (ctl.rd_en) begin
        phase_r <= phase_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) cap_phase_r <= phase_r;
  end

  assign sts.last_read = (cmd_r != CMD_FLIP) || (phase_r == PH_SOUTH);

  // Grid addresses with wrap at the torus edges
  assign site_addr = {row_r, col_r};

  always_comb begin
    case (phase_r)
      PH_SITE:  rd_addr = site_addr;
      PH_EAST:  rd_addr = {row_r, col_r + COORD_W'(1)};
      PH_WEST:  rd_addr = {row_r, col_r - COORD_W'(1)};
      PH_NORTH: rd_addr = {row_r + COORD_W'(1), col_r};
      PH_SOUTH: rd_addr = {row_r - COORD_W'(1), col_r};
      default:  rd_addr = site_addr;
    endcase
  end

  // Single-port spin memory: clearing write, write-back or registered read
  always_ff @(posedge clk) begin
    if (ctl.clr_wr) begin
      grid_mem[clr_addr_r] <= 1'b1;
    end else if (mem_we) begin
      grid_mem[site_addr] <= new_bit;
    end else if (ctl.rd_en) begin
      mem_q_r <= grid_mem[rd_addr];
    end
  end

  // Sweep the memory to all +1 after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (ctl.clr_wr) begin
      clr_addr_r <= clr_addr_r + CELL_W'(1);
    end
  end

  assign sts.clr_last = &clr_addr_r;

  // Capture the site spin and count the +1 neighbours
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ups_r <= '0;
    end else if (cap_en_r) begin
      if (cap_phase_r == PH_SITE) begin
        site_r <= mem_q_r;
      end else begin
        ups_r <= ups_r + {2'b00, mem_q_r};
      end
    end
  end

  // Threshold lookup and acceptance test
  always_comb begin
    if (site_r) begin
      tbl_idx = {1'b0, ups_r};
    end else begin
      tbl_idx = TBL_IDX_W'(TBL_DEPTH - 1) - {1'b0, ups_r};
    end
    thr         = thr_tbl_r[tbl_idx];
    accept_flip = (cmd_r == CMD_FLIP) && ({1'b0, draw_r} < thr);
  end

  // New spin value and whether the grid changes
  always_comb begin
    case (cmd_r)
      CMD_FLIP: begin
        new_bit  = accept_flip ? ~site_r : site_r;
        do_write = accept_flip;
      end
      CMD_WRITE: begin
        new_bit  = value_r[0];
        do_write = (value_r[0] != site_r);
      end
      default: begin
        new_bit  = site_r;
        do_write = 1'b0;
      end
    endcase
  end

  assign mem_we = ctl.exec && do_write;

  // Keep the magnetization in step with each changed spin
  always_comb begin
    total_nxt = total_r;
    if (do_write) begin
      total_nxt = new_bit ? (total_r + MAG_W'(2)) : (total_r - MAG_W'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= MAG_RESET;
    end else if (ctl.exec) begin
      total_r <= total_nxt;
    end
  end

  // Threshold table; drop loads beyond the last entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        thr_tbl_r[i] <= '0;
      end
    end else if (ctl.exec && (cmd_r == CMD_LOAD) && (entry_r < TBL_IDX_W'(TBL_DEPTH))) begin
      thr_tbl_r[entry_r] <= value_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_spin_r <= new_bit;
      out_flip_r <= accept_flip;
      out_mag_r  <= total_nxt;
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {2'b00, out_mag_r, out_flip_r, out_spin_r};

endmodule
`default_nettype wire

FILE: rtl/core/ising_metropolis_flip.sv
`default_nettype none
// Single-spin Metropolis update on a 32 x 32 torus of spins held in a one-bit-wide,
// single-port memory, with a running magnetization and a ten-entry acceptance
// threshold table. Each input transfer gives one result transfer. A flip attempt
// (cmd 0) reads the site and its four wrapped neighbours one per cycle through the
// single memory port; write, load and read commands read the site only. After reset
// the block writes every site to +1, one per cycle, and holds in_tready low until
// the clearing pass ends. A finished result waits in an output register while the
// next item is taken in; a new result is loaded only once the previous one has been
// transferred.
module ising_metropolis_flip (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // x[4:0], y[9:5], random_draw[41:10], entry_index[45:42], load_value[78:46]
  input  wire logic [ifp_pkg::IN_DATA_W-1:0] in_tdata,
  // cmd[1:0]
  input  wire logic [ifp_pkg::IN_USER_W-1:0] in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // spin[0], flipped[1], magnetization[13:2]
  output logic [ifp_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import ifp_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ifp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ifp_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .ctl        (ctl),
    .sts        (sts)
  );

  // Never overwrite a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |-> !(out_tvalid && !out_tready))
    else $error("result register overwritten");

  // No input transfer during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr_wr |-> !in_tready)
    else $error("input taken during clearing pass");

  // Each input transfer starts the grid reads in the next cycle
  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> ctl.rd_en)
    else $error("grid read did not follow input transfer");

  // The magnetization of an even-sized grid stays even
  a_mag_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[2])
    else $error("odd magnetization");

endmodule
`default_nettype wire
